FILE: rtl/cla_pkg.sv
// Shared constants, codes and types of the cooldown lock arbiter.
`default_nettype none
package cla_pkg;

  localparam int ID_W        = 8;
  localparam int TIME_W      = 48;
  localparam int COOL_W      = 16;
  localparam int OP_W        = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int ENTRY_W     = ID_W + TIME_W;
  localparam int US_PER_MS   = 1000;
  // cooldown_ms * 1000 stays below 2^26
  localparam int PROD_W      = 26;

  localparam int MAX_WAITERS_DEF = 16;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [OP_W-1:0] OP_REQUEST  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WITHDRAW = 2'd2;
  localparam logic [OP_W-1:0] OP_POLL     = 2'd3;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_COOLDOWN = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_EDF  = 1'b1;

  typedef struct packed {
    logic              policy_mode;
    logic [COOL_W-1:0] cooldown_ms;
  } cla_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/cooldown_lock_arbiter_top.sv
// Top level of the cooldown lock arbiter: sequencer, waiter memory and config.
`default_nettype none
// Arbiter for one shared lock. Each word on the item channel is a request,
// release, withdraw or poll; each produces exactly one result word. The
// waiter list lives in a MAX_WAITERS-deep RAM with registered read data and
// is only ever read below the fill count, so no clearing pass follows reset.
// Items are handled one at a time by a sequencer; the next item is accepted
// while the previous result still waits in the output register. A request or
// poll checks for a grant; a release first frees the lock and starts the
// cooldown. A grant adds a memory scan (of all waiters in EDF mode, of the
// first in FIFO mode) plus a shift of the entries behind the winner. A
// withdraw adds a scan up to the first matching entry and the same shift.
// Scans and shifts go through the single read port of the waiter RAM.
module cooldown_lock_arbiter_top
  import cla_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  // item channel
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [OP_W-1:0]        operation,
  input  wire logic [ID_W-1:0]        requester_id,
  input  wire logic [TIME_W-1:0]      deadline,
  input  wire logic [TIME_W-1:0]      now_time,
  // result channel
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic                        granted,
  output logic      [ID_W-1:0]        granted_id,
  output logic                        request_dropped,
  output logic      [COUNT_OUT_W-1:0] waiting_count,
  output logic                        lock_held
);

  localparam int AW    = $clog2(MAX_WAITERS);
  localparam int CW    = $clog2(MAX_WAITERS + 1);
  localparam int SUM_W = TIME_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RELADD = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  cla_cfg_t cfg;

  cla_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [2:0]        state;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;
  logic [PROD_W-1:0] prod;
  logic              lock_busy;
  logic [TIME_W-1:0] free_after;
  logic [CW-1:0]     total;
  logic              dropped_q;
  logic              granted_q;
  logic [ID_W-1:0]   gid_q;
  logic [CW-1:0]     scan_idx;
  logic [CW-1:0]     scan_lim;
  logic              scan_grant;
  logic              cmp_valid;
  logic [CW-1:0]     cmp_idx;
  logic [CW-1:0]     best_pos;
  logic [ID_W-1:0]   best_id;
  logic [TIME_W-1:0] best_dl;
  logic [CW-1:0]     sh_rd;
  logic [AW-1:0]     sh_wa;
  logic              sh_wv;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               item_fire;
  logic               list_full;
  logic               scan_issue;
  logic               shift_issue;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_dl;
  logic               edf_better;
  logic [SUM_W-1:0]   cd_sum;
  logic [TIME_W-1:0]  cd_end;
  logic [CW-1:0]      sh_dst;
  logic               grant_ok;

  cla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WAITERS)
  ) u_waiters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign list_full  = (total >= CW'(MAX_WAITERS));

  assign rd_id = ram_rdata[ENTRY_W-1 -: ID_W];
  assign rd_dl = ram_rdata[TIME_W-1:0];
  assign edf_better = (rd_dl < best_dl) || ((rd_dl == best_dl) && (rd_id < best_id));

  // saturate the end of the cooldown at the top of the time range
  assign cd_sum = SUM_W'(now_q) + SUM_W'(prod);
  assign cd_end = cd_sum[TIME_W] ? {TIME_W{1'b1}} : cd_sum[TIME_W-1:0];

  assign scan_issue  = (state == S_SCAN) && (scan_idx < scan_lim);
  assign shift_issue = (state == S_SHIFT) && (sh_rd < total);
  assign sh_dst      = sh_rd - CW'(1);
  assign grant_ok    = !lock_busy && (now_q >= free_after) && (total != '0);

  // Reads and writes are sequenced so that no read hits an entry still being
  // written: the shift reads one entry ahead of the slot it fills.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = total[AW-1:0];
    ram_wdata = {requester_id, deadline};
    ram_raddr = scan_idx[AW-1:0];
    if (item_fire && (operation == OP_REQUEST) && !list_full) begin
      ram_we = 1'b1;
    end
    if (state == S_SHIFT) begin
      ram_raddr = sh_rd[AW-1:0];
      if (sh_wv) begin
        ram_we    = 1'b1;
        ram_waddr = sh_wa;
        ram_wdata = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lock_busy    <= 1'b0;
      free_after   <= '0;
      total        <= '0;
      result_valid <= 1'b0;
      cmp_valid    <= 1'b0;
      sh_wv        <= 1'b0;
      scan_grant   <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_fire) begin
            id_q      <= requester_id;
            now_q     <= now_time;
            dropped_q <= 1'b0;
            granted_q <= 1'b0;
            gid_q     <= '0;
            prod      <= PROD_W'(cfg.cooldown_ms) * PROD_W'(US_PER_MS);
            case (operation)
              OP_REQUEST: begin
                if (list_full) begin
                  dropped_q <= 1'b1;
                end else begin
                  total <= total + CW'(1);
                end
                state <= S_CHECK;
              end
              OP_RELEASE: state <= S_RELADD;
              OP_WITHDRAW: begin
                scan_idx   <= '0;
                scan_lim   <= total;
                scan_grant <= 1'b0;
                cmp_valid  <= 1'b0;
                state      <= S_SCAN;
              end
              default: state <= S_CHECK;
            endcase
          end
        end

        S_RELADD: begin
          lock_busy  <= 1'b0;
          free_after <= cd_end;
          state      <= S_CHECK;
        end

        S_CHECK: begin
          if (grant_ok) begin
            scan_idx   <= '0;
            scan_lim   <= (cfg.policy_mode == POLICY_EDF) ? total : CW'(1);
            scan_grant <= 1'b1;
            cmp_valid  <= 1'b0;
            state      <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end

        S_SCAN: begin
          scan_idx  <= scan_idx + CW'(scan_issue);
          cmp_valid <= scan_issue;
          cmp_idx   <= scan_idx;
          if (!scan_issue && !cmp_valid) begin
            if (scan_grant) begin
              // take the winner and close its gap
              granted_q <= 1'b1;
              gid_q     <= best_id;
              lock_busy <= 1'b1;
              sh_rd     <= best_pos + CW'(1);
              sh_wv     <= 1'b0;
              state     <= S_SHIFT;
            end else begin
              state <= S_CHECK;
            end
          end else if (cmp_valid) begin
            if (scan_grant) begin
              if ((cmp_idx == '0) || edf_better) begin
                best_pos <= cmp_idx;
                best_id  <= rd_id;
                best_dl  <= rd_dl;
              end
            end else if (rd_id == id_q) begin
              // oldest match found: drop any read still in flight
              sh_rd     <= cmp_idx + CW'(1);
              sh_wv     <= 1'b0;
              state     <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          sh_rd <= sh_rd + CW'(shift_issue);
          sh_wa <= sh_dst[AW-1:0];
          sh_wv <= shift_issue;
          if (!shift_issue && !sh_wv) begin
            total <= total - CW'(1);
            state <= scan_grant ? S_DONE : S_CHECK;
          end
        end

        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid    <= 1'b1;
            granted         <= granted_q;
            granted_id      <= gid_q;
            request_dropped <= dropped_q;
            waiting_count   <= COUNT_OUT_W'(total);
            lock_held       <= lock_busy;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_WAITERS))
    else $error("waiter count beyond list depth");

  a_grant_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && granted |-> lock_held)
    else $error("grant reported while lock not held");

  a_no_grant_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && !granted |-> granted_id == '0)
    else $error("winner id without a grant");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> state != S_IDLE)
    else $error("sequencer idle right after taking a word");

endmodule
`default_nettype wire

FILE: rtl/cla_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/cla_cfg.sv
// APB register block holding the arbitration policy and the cooldown.
`default_nettype none
module cla_cfg
  import cla_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cla_cfg_t                   cfg
);

  logic reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_mode <= POLICY_FIFO;
      cfg.cooldown_ms <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_POLICY:   cfg.policy_mode <= pwdata[0];
        REG_COOLDOWN: cfg.cooldown_ms <= pwdata[COOL_W-1:0];
        default:      cfg.cooldown_ms <= cfg.cooldown_ms;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_POLICY:   prdata[0]          = cfg.policy_mode;
      REG_COOLDOWN: prdata[COOL_W-1:0] = cfg.cooldown_ms;
      default:      prdata             = '0;
    endcase
  end

  // sub-word address bits are ignored
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule
`default_nettype wire
